FILE: hw/rtl/lcdr_pkg.sv
`timescale 1ns / 1ps

package lcdr_pkg;

  // Request commands
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  // Register offsets
  localparam logic [3:0] OFF_USEC_B0   = 4'd0;
  localparam logic [3:0] OFF_USEC_B1   = 4'd1;
  localparam logic [3:0] OFF_USEC_B2   = 4'd2;
  localparam logic [3:0] OFF_USEC_B3   = 4'd3;
  localparam logic [3:0] OFF_SEC_B0    = 4'd4;
  localparam logic [3:0] OFF_SEC_B1    = 4'd5;
  localparam logic [3:0] OFF_SEC_B2    = 4'd6;
  localparam logic [3:0] OFF_SEC_B3    = 4'd7;
  localparam logic [3:0] OFF_MSEC_B0   = 4'd8;
  localparam logic [3:0] OFF_MSEC_B1   = 4'd9;
  localparam logic [3:0] OFF_MSEC_B2   = 4'd10;
  localparam logic [3:0] OFF_MSEC_B3   = 4'd11;
  localparam logic [3:0] OFF_DEADLINE  = 4'd12;
  localparam logic [3:0] OFF_DEADLINE_HI = 4'd13;
  localparam logic [3:0] OFF_RANDOM_A  = 4'd14;
  localparam logic [3:0] OFF_RANDOM_B  = 4'd15;

  localparam int USEC_W = 20;
  localparam int SEC_W  = 32;
  localparam int MSEC_W = 30;
  localparam int SUB_W  = 10;

  localparam logic [USEC_W-1:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [SUB_W-1:0]  USEC_PER_MS  = 10'd1000;

  localparam int MS_WRAP_SECONDS_DEF = 1000000;

  localparam logic [31:0] LFSR_TAPS  = 32'h8020_0003;
  localparam logic [31:0] RESET_SEED = 32'h0000_0001;

  localparam logic [7:0] BYTE_ONES = 8'hFF;

  typedef struct packed {
    logic [USEC_W-1:0] usec;
    logic [SEC_W-1:0]  sec;
    logic [MSEC_W-1:0] msec;
  } live_t;

  function automatic logic [7:0] byte_sel(input logic [31:0] v, input logic [1:0] n);
    logic [31:0] sh;
    sh = v >> {n, 3'b000};
    return sh[7:0];
  endfunction

  // Galois step, shifting right
  function automatic logic [31:0] lfsr_step(input logic [31:0] s);
    logic [31:0] n;
    n = s >> 1;
    if (s[0]) begin
      n = n ^ LFSR_TAPS;
    end
    return n;
  endfunction

endpackage

FILE: hw/rtl/lcdr_timebase.sv
`timescale 1ns / 1ps

module lcdr_timebase #(
  parameter int MS_WRAP_SECONDS = lcdr_pkg::MS_WRAP_SECONDS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            tick,
  output lcdr_pkg::live_t live
);

  localparam int WRAP_W = $clog2(MS_WRAP_SECONDS + 1);
  localparam logic [WRAP_W-1:0] WRAP_LAST = WRAP_W'(MS_WRAP_SECONDS - 1);

  logic [lcdr_pkg::USEC_W-1:0] usec, usec_next, usec_inc;
  logic [lcdr_pkg::SEC_W-1:0]  sec, sec_next;
  logic [lcdr_pkg::MSEC_W-1:0] msec, msec_next;
  logic [lcdr_pkg::SUB_W-1:0]  sub, sub_next, sub_inc;
  logic [WRAP_W-1:0]           wrap, wrap_next;

  always_comb begin
    usec_next = usec;
    sec_next  = sec;
    msec_next = msec;
    sub_next  = sub;
    wrap_next = wrap;
    sub_inc   = sub + 1'b1;
    usec_inc  = usec + 1'b1;
    if (tick) begin
      if (sub_inc >= lcdr_pkg::USEC_PER_MS) begin
        sub_next  = '0;
        msec_next = msec + 1'b1;
      end else begin
        sub_next = sub_inc;
      end
      if (usec_inc >= lcdr_pkg::USEC_PER_SEC) begin
        usec_next = '0;
        sub_next  = '0;
        sec_next  = sec + 1'b1;
        // restart milliseconds when seconds land on a multiple of the wrap
        if (sec == '1 || wrap == WRAP_LAST) begin
          wrap_next = '0;
          msec_next = '0;
        end else begin
          wrap_next = wrap + 1'b1;
        end
      end else begin
        usec_next = usec_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      usec <= '0;
      sec  <= '0;
      msec <= '0;
      sub  <= '0;
      wrap <= '0;
    end else begin
      usec <= usec_next;
      sec  <= sec_next;
      msec <= msec_next;
      sub  <= sub_next;
      wrap <= wrap_next;
    end
  end

  assign live.usec = usec;
  assign live.sec  = sec;
  assign live.msec = msec;

  a_usec_range : assert property (@(posedge clk) disable iff (rst)
    usec < lcdr_pkg::USEC_PER_SEC) else $error("microseconds out of range");

  a_sub_range : assert property (@(posedge clk) disable iff (rst)
    sub < lcdr_pkg::USEC_PER_MS) else $error("sub-millisecond count out of range");

  a_wrap_range : assert property (@(posedge clk) disable iff (rst)
    wrap <= WRAP_LAST) else $error("second wrap count out of range");

endmodule

FILE: hw/rtl/lcdr_lfsr.sv
`timescale 1ns / 1ps

module lcdr_lfsr (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  logic [31:0] seed,
  input  logic        advance,
  output logic [7:0]  rand_byte
);

  logic [31:0] state, state_next, stepped;

  assign stepped   = lcdr_pkg::lfsr_step(state);
  assign rand_byte = stepped[7:0];

  always_comb begin
    state_next = state;
    if (load) begin
      state_next = (seed == '0) ? lcdr_pkg::RESET_SEED : seed;
    end else if (advance) begin
      state_next = stepped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcdr_pkg::RESET_SEED;
    end else begin
      state <= state_next;
    end
  end

  a_never_zero : assert property (@(posedge clk) disable iff (rst)
    state != '0) else $error("shift register locked at zero");

  a_zero_seed : assert property (@(posedge clk) disable iff (rst)
    load && seed == '0 |=> state == lcdr_pkg::RESET_SEED) else $error("zero seed not replaced");

  a_advance : assert property (@(posedge clk) disable iff (rst)
    !load && advance |=> state == lcdr_pkg::lfsr_step($past(state)))
    else $error("shift register step wrong");

endmodule

FILE: hw/rtl/latched_clock_deadline_registers_core.sv
`timescale 1ns / 1ps

// Path: a request is registered in the stage on acceptance; a read then fires from the
//   stage and loads its byte and rsp_valid once the response register is free.
// Throughput: one request per cycle; only a stalled, full response register holds a read.
// Reset: synchronous, active high; clears all counters, latches and the deadline,
//   and loads the shift register with seed 1. No clearing pass is needed.
module latched_clock_deadline_registers_core #(
  parameter int MS_WRAP_SECONDS = lcdr_pkg::MS_WRAP_SECONDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [1:0]  command,
  input  logic [3:0]  reg_offset,
  input  logic [7:0]  write_data,
  // response channel
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [7:0]  read_data,
  // seed register write port
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] random_seed
);

  // Request stage register
  logic                 stage_valid;
  lcdr_pkg::cmd_t       stage_command;
  logic [3:0]           stage_offset;
  logic [7:0]           stage_data;

  logic stage_fire;
  logic stage_is_read;
  logic out_free;

  // Latched values, snapshot and deadline
  logic [lcdr_pkg::USEC_W-1:0] lat_usec, lat_usec_next;
  logic [lcdr_pkg::SEC_W-1:0]  lat_sec, lat_sec_next;
  logic [lcdr_pkg::MSEC_W-1:0] lat_msec, lat_msec_next;
  logic [lcdr_pkg::MSEC_W-1:0] snap, snap_next;
  logic [31:0]                 deadline, deadline_next;

  logic            tick;
  logic            rand_advance;
  logic [7:0]      rand_byte;
  logic [7:0]      rd_byte;
  lcdr_pkg::live_t live;

  // The seed register is always writable; writes must arrive only while idle, which the block does not enforce.
  assign cfg_ready = 1'b1;

  // A read may only leave the stage when the response register can take it.
  assign out_free      = !rsp_valid || !rsp_stall;
  assign stage_is_read = (stage_command == lcdr_pkg::CMD_READ);
  assign stage_fire    = stage_valid && (!stage_is_read || out_free);
  assign cmd_stall     = stage_valid && !stage_fire;

  // Capture the request whenever the stage is empty or emptying.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!cmd_stall) begin
      stage_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      stage_command <= lcdr_pkg::cmd_t'(command);
      stage_offset  <= reg_offset;
      stage_data    <= write_data;
    end
  end

  lcdr_timebase #(
    .MS_WRAP_SECONDS(MS_WRAP_SECONDS)
  ) u_timebase (
    .clk  (clk),
    .rst  (rst),
    .tick (tick),
    .live (live)
  );

  lcdr_lfsr u_lfsr (
    .clk       (clk),
    .rst       (rst),
    .load      (cfg_valid && cfg_ready),
    .seed      (random_seed),
    .advance   (rand_advance),
    .rand_byte (rand_byte)
  );

  // Decode the staged request: advance the clock, update the deadline or
  // form the read byte, with any latching or shift-register side effect of the read.
  always_comb begin
    lat_usec_next = lat_usec;
    lat_sec_next  = lat_sec;
    lat_msec_next = lat_msec;
    snap_next     = snap;
    deadline_next = deadline;
    tick          = 1'b0;
    rand_advance  = 1'b0;
    rd_byte       = lcdr_pkg::BYTE_ONES;
    if (stage_fire) begin
      unique case (stage_command)
        lcdr_pkg::CMD_TICK: begin
          tick = 1'b1;
        end
        lcdr_pkg::CMD_WRITE: begin
          if (stage_offset == lcdr_pkg::OFF_DEADLINE) begin
            snap_next     = live.msec;
            deadline_next = {24'b0, stage_data};
          end else if (stage_offset == lcdr_pkg::OFF_DEADLINE_HI) begin
            // high byte joins the low byte, then the deadline goes relative to the snapshot
            deadline_next = (deadline | {16'b0, stage_data, 8'b0}) + {2'b0, snap};
          end
        end
        lcdr_pkg::CMD_READ: begin
          unique case (stage_offset)
            lcdr_pkg::OFF_USEC_B0, lcdr_pkg::OFF_USEC_B1, lcdr_pkg::OFF_USEC_B2: begin
              rd_byte = lcdr_pkg::byte_sel({12'b0, lat_usec}, stage_offset[1:0]);
            end
            lcdr_pkg::OFF_USEC_B3: begin
              // latch microseconds and seconds together
              lat_usec_next = live.usec;
              lat_sec_next  = live.sec;
              rd_byte       = lcdr_pkg::byte_sel({12'b0, live.usec}, 2'd3);
            end
            lcdr_pkg::OFF_SEC_B0, lcdr_pkg::OFF_SEC_B1,
            lcdr_pkg::OFF_SEC_B2, lcdr_pkg::OFF_SEC_B3: begin
              rd_byte = lcdr_pkg::byte_sel(lat_sec, stage_offset[1:0]);
            end
            lcdr_pkg::OFF_MSEC_B0, lcdr_pkg::OFF_MSEC_B1, lcdr_pkg::OFF_MSEC_B2: begin
              rd_byte = lcdr_pkg::byte_sel({2'b0, lat_msec}, stage_offset[1:0]);
            end
            lcdr_pkg::OFF_MSEC_B3: begin
              lat_msec_next = live.msec;
              snap_next     = live.msec;
              rd_byte       = lcdr_pkg::byte_sel({2'b0, live.msec}, 2'd3);
            end
            lcdr_pkg::OFF_DEADLINE: begin
              // poll: all ones while the deadline is still ahead
              snap_next = live.msec;
              rd_byte   = (deadline > {2'b0, live.msec}) ? lcdr_pkg::BYTE_ONES : 8'h00;
            end
            lcdr_pkg::OFF_RANDOM_A, lcdr_pkg::OFF_RANDOM_B: begin
              rand_advance = 1'b1;
              rd_byte      = rand_byte;
            end
            default: begin
              rd_byte = lcdr_pkg::BYTE_ONES;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lat_usec <= '0;
      lat_sec  <= '0;
      lat_msec <= '0;
      snap     <= '0;
      deadline <= '0;
    end else begin
      lat_usec <= lat_usec_next;
      lat_sec  <= lat_sec_next;
      lat_msec <= lat_msec_next;
      snap     <= snap_next;
      deadline <= deadline_next;
    end
  end

  // Response register: load on a read, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (stage_fire && stage_is_read) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_fire && stage_is_read) begin
      read_data <= rd_byte;
    end
  end

  a_stall_needs_stage : assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> stage_valid) else $error("request stalled with empty stage");

  a_nonread_flows : assert property (@(posedge clk) disable iff (rst)
    stage_valid && !stage_is_read |-> !cmd_stall) else $error("non-read request held");

  a_read_responds : assert property (@(posedge clk) disable iff (rst)
    stage_fire && stage_is_read |=> rsp_valid) else $error("read produced no response");

endmodule

FILE: tb/sv/latched_clock_deadline_registers_core_tb.sv
`timescale 1ns / 1ps

module latched_clock_deadline_registers_core_tb;
  import lcdr_pkg::*;

  // Smallest wrap: the millisecond count restarts at every new second.
  localparam int MS_WRAP = 1;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int SETTLE_CYCLES = 4;     // request to response passes the stage and response registers
  localparam int HOLD_CYCLES   = 150;   // long receiver hold-off
  localparam int QUIET_LIMIT   = 2000;  // cycles with no handshake at all

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        cmd_valid   = 1'b0;
  logic        cmd_stall;
  logic [1:0]  command     = CMD_TICK;
  logic [3:0]  reg_offset  = OFF_USEC_B0;
  logic [7:0]  write_data  = 8'h00;
  logic        rsp_valid;
  logic        rsp_stall   = 1'b0;
  logic [7:0]  read_data;
  logic        cfg_valid   = 1'b0;
  logic        cfg_ready;
  logic [31:0] random_seed = RESET_SEED;

  latched_clock_deadline_registers_core #(
    .MS_WRAP_SECONDS(MS_WRAP)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .command    (command),
    .reg_offset (reg_offset),
    .write_data (write_data),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .read_data  (read_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .random_seed(random_seed)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the register block: live clock, latches, deadline, shift
  // register. It is advanced at the edge on which each request is accepted.
  // ---------------------------------------------------------------------------
  logic [USEC_W-1:0] clk_usec, lat_usec;
  logic [SEC_W-1:0]  clk_sec, lat_sec;
  logic [MSEC_W-1:0] clk_msec, lat_msec, msec_snap;
  logic [SUB_W-1:0]  clk_sub;
  logic [31:0]       deadline, lfsr;

  logic [7:0] read_bytes_due[$];  // read bytes still owed by the block

  int unsigned errors          = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned rsp_stall_pct   = 0;

  // Receiver hold-off: the stimulus flips hold_flip, the receiver notices
  // the change and holds stall high while it counts hold_left down from HOLD_CYCLES.
  logic hold_flip = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  function automatic void load_seed(input logic [31:0] s);
    // a zero seed would lock the shift register up, so take 1 instead
    lfsr = (s == 32'd0) ? 32'd1 : s;
  endfunction

  function automatic void clock_regs_reset();
    clk_usec  = '0;
    clk_sec   = '0;
    clk_msec  = '0;
    clk_sub   = '0;
    lat_usec  = '0;
    lat_sec   = '0;
    lat_msec  = '0;
    msec_snap = '0;
    deadline  = '0;
    load_seed(RESET_SEED);
  endfunction

  function automatic void tick_clock();
    clk_sub = clk_sub + 1'b1;
    if (clk_sub >= USEC_PER_MS) begin
      clk_sub  = '0;
      clk_msec = clk_msec + 1'b1;
    end
    clk_usec = clk_usec + 1'b1;
    if (clk_usec >= USEC_PER_SEC) begin
      clk_usec = '0;
      clk_sub  = '0;
      clk_sec  = clk_sec + 1'b1;
      if (clk_sec % 32'(MS_WRAP) == 32'd0) begin
        clk_msec = '0;
      end
    end
  endfunction

  function automatic logic [7:0] byte_at(input logic [31:0] v, input logic [1:0] n);
    return v[8*n +: 8];
  endfunction

  function automatic logic [7:0] register_read(input logic [3:0] off);
    case (off)
      OFF_USEC_B0, OFF_USEC_B1, OFF_USEC_B2: return byte_at(32'(lat_usec), off[1:0]);
      OFF_USEC_B3: begin
        lat_usec = clk_usec;
        lat_sec  = clk_sec;
        return byte_at(32'(lat_usec), 2'd3);
      end
      OFF_SEC_B0, OFF_SEC_B1, OFF_SEC_B2, OFF_SEC_B3: return byte_at(lat_sec, off[1:0]);
      OFF_MSEC_B0, OFF_MSEC_B1, OFF_MSEC_B2: return byte_at(32'(lat_msec), off[1:0]);
      OFF_MSEC_B3: begin
        msec_snap = clk_msec;
        lat_msec  = clk_msec;
        return byte_at(32'(lat_msec), 2'd3);
      end
      OFF_DEADLINE: begin
        msec_snap = clk_msec;
        return (deadline > 32'(clk_msec)) ? BYTE_ONES : 8'h00;
      end
      OFF_RANDOM_A, OFF_RANDOM_B: begin
        lfsr = (lfsr >> 1) ^ (lfsr[0] ? LFSR_TAPS : 32'd0);
        return lfsr[7:0];
      end
      default: return BYTE_ONES;
    endcase
  endfunction

  function automatic void register_write(input logic [3:0] off, input logic [7:0] d);
    if (off == OFF_DEADLINE) begin
      msec_snap = clk_msec;
      deadline  = {24'd0, d};
    end else if (off == OFF_DEADLINE_HI) begin
      deadline = (deadline | {16'd0, d, 8'd0}) + 32'(msec_snap);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Edge monitor: check the response, then advance the shadow copy with
  // whatever was accepted on the seed port and the request channel. Also
  // run the watchdog on handshake activity.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : track
    logic [7:0] want;
    if (rst) begin
      clock_regs_reset();
      quiet_cycles = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (read_bytes_due.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected read response: read_data=%02h", read_data);
          end
        end else begin
          want = read_bytes_due.pop_front();
          if (read_data !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("read_data mismatch: expected %02h actual %02h", want, read_data);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        load_seed(random_seed);
      end
      if (cmd_valid && !cmd_stall) begin
        case (command)
          CMD_TICK:  tick_clock();
          CMD_WRITE: register_write(reg_offset, write_data);
          CMD_READ:  read_bytes_due.push_back(register_read(reg_offset));
          default: ;
        endcase
      end
      if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Response side: random stall, or a long hold-off when asked for one.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      hold_left <= 0;
      hold_seen <= hold_flip;
    end else if (hold_flip != hold_seen) begin
      hold_seen <= hold_flip;
      hold_left <= HOLD_CYCLES;
      rsp_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver: idle at random, then offer one request and hold it until
  // the block takes it. Valid stays high afterwards; the next call keeps it high
  // with a new request unless it idles first, and a wait drops it.
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [1:0] c, input logic [3:0] o, input logic [7:0] d);
    while ($urandom_range(99) < sender_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid  <= 1'b1;
    command    <= c;
    reg_offset <= o;
    write_data <= d;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
  endtask

  // Drop valid, wait for every owed byte, then let the pipeline settle.
  task automatic wait_idle();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (read_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] s);
    wait_idle();
    cfg_valid   <= 1'b1;
    random_seed <= s;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Power-up value of every offset, the unused command, a write to a byte that
  // ignores it, ticks, a latch, and a deadline set from all-ones bytes.
  task automatic test_directed();
    sender_idle_pct = 0;
    rsp_stall_pct   = 0;
    for (int i = 0; i < 16; i++) begin
      send_request(CMD_READ, 4'(i), 8'h00);
    end
    send_request(CMD_UNUSED, OFF_RANDOM_B, 8'hFF);
    send_request(CMD_WRITE, OFF_USEC_B0, 8'hFF);
    send_request(CMD_TICK, OFF_RANDOM_B, 8'hFF);
    send_request(CMD_TICK, OFF_USEC_B0, 8'h00);
    send_request(CMD_READ, OFF_USEC_B3, 8'hFF);
    send_request(CMD_WRITE, OFF_DEADLINE, 8'hFF);
    send_request(CMD_WRITE, OFF_DEADLINE_HI, 8'hFF);
    send_request(CMD_READ, OFF_DEADLINE, 8'h00);
    send_request(CMD_READ, OFF_USEC_B0, 8'h00);
    wait_idle();
  endtask

  // Reload the shift register from the zero seed, seed 1, all ones, the top bit
  // alone and a random one, and draw a few bytes from each.
  task automatic test_seed();
    logic [31:0] seeds [5];
    seeds = '{32'h0000_0000, RESET_SEED, 32'hFFFF_FFFF, 32'h8000_0000, $urandom};
    rsp_stall_pct = 20;
    foreach (seeds[i]) begin
      write_seed(seeds[i]);
      repeat (6) begin
        send_request(CMD_READ, $urandom_range(1) ? OFF_RANDOM_A : OFF_RANDOM_B, 8'($urandom));
      end
    end
    wait_idle();
  endtask

  // Arm a deadline one millisecond out, run the clock up to the last
  // microsecond of the current millisecond, latch and read every counter,
  // then step across the millisecond boundary and read again.
  task automatic test_rollover();
    int unsigned gap;
    wait_idle();
    sender_idle_pct = 0;
    rsp_stall_pct   = 0;
    send_request(CMD_WRITE, OFF_DEADLINE, 8'h01);
    send_request(CMD_WRITE, OFF_DEADLINE_HI, 8'h00);
    gap = 32'(USEC_PER_MS) - 32'd1 - 32'(clk_sub);
    repeat (gap) send_request(CMD_TICK, 4'($urandom), 8'($urandom));
    repeat (2) begin
      send_request(CMD_READ, OFF_USEC_B3, 8'($urandom));
      send_request(CMD_READ, OFF_USEC_B0, 8'($urandom));
      send_request(CMD_READ, OFF_USEC_B1, 8'($urandom));
      send_request(CMD_READ, OFF_USEC_B2, 8'($urandom));
      send_request(CMD_READ, OFF_SEC_B0, 8'($urandom));
      send_request(CMD_READ, OFF_MSEC_B3, 8'($urandom));
      send_request(CMD_READ, OFF_MSEC_B0, 8'($urandom));
      send_request(CMD_READ, OFF_MSEC_B1, 8'($urandom));
      send_request(CMD_READ, OFF_DEADLINE, 8'($urandom));
      send_request(CMD_TICK, 4'($urandom), 8'($urandom));
    end
    wait_idle();
  endtask

  // Mostly well-formed access patterns with random content: tick runs,
  // latch-then-read of the clock bytes, deadline set and poll, shift
  // register draws; the rest is noise.
  task automatic test_random(input int unsigned n_items, input int unsigned idle_pct,
                             input int unsigned stall_pct);
    int unsigned done, kind, k;
    logic [3:0] o;
    sender_idle_pct = idle_pct;
    rsp_stall_pct   = stall_pct;
    done = 0;
    while (done < n_items) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        k = $urandom_range(1, 40);
        repeat (k) send_request(CMD_TICK, 4'($urandom), 8'($urandom));
        done += k;
      end else if (kind < 50) begin
        // latch microseconds and seconds, then read their bytes
        send_request(CMD_READ, OFF_USEC_B3, 8'($urandom));
        k = $urandom_range(2, 6);
        repeat (k) begin
          o = 4'($urandom_range(0, 6));
          if (o >= OFF_USEC_B3) o = o + 1'b1;
          send_request(CMD_READ, o, 8'($urandom));
        end
        done += k + 1;
      end else if (kind < 62) begin
        send_request(CMD_READ, OFF_MSEC_B3, 8'($urandom));
        k = $urandom_range(1, 4);
        repeat (k) send_request(CMD_READ, 4'($urandom_range(8, 10)), 8'($urandom));
        done += k + 1;
      end else if (kind < 78) begin
        // small deadlines mostly; a short tick burst may sit between the polls
        send_request(CMD_WRITE, OFF_DEADLINE,
                     ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2)));
        send_request(CMD_WRITE, OFF_DEADLINE_HI,
                     ($urandom_range(3) == 0) ? 8'($urandom) : 8'h00);
        send_request(CMD_READ, OFF_DEADLINE, 8'($urandom));
        if ($urandom_range(3) == 0) begin
          k = $urandom_range(1, 40);
          repeat (k) send_request(CMD_TICK, 4'($urandom), 8'($urandom));
          done += k;
        end
        send_request(CMD_READ, OFF_DEADLINE, 8'($urandom));
        done += 4;
      end else if (kind < 88) begin
        k = $urandom_range(1, 6);
        repeat (k) begin
          send_request(CMD_READ, $urandom_range(1) ? OFF_RANDOM_A : OFF_RANDOM_B, 8'($urandom));
        end
        done += k;
      end else begin
        send_request(2'($urandom), 4'($urandom), 8'($urandom));
        done++;
      end
    end
  endtask

  // Hold the receiver off for a long stretch while requests keep coming so
  // the block backs up and stalls its input; then pause the sender until
  // every owed byte is in, and go on.
  task automatic test_backpressure();
    sender_idle_pct = 0;
    rsp_stall_pct   = 10;
    hold_flip <= ~hold_flip;
    repeat (60) begin
      send_request(($urandom_range(3) == 0) ? CMD_TICK : CMD_READ, 4'($urandom), 8'($urandom));
    end
    wait_idle();
    sender_idle_pct = 20;
    repeat (30) send_request(CMD_READ, 4'($urandom), 8'($urandom));
    wait_idle();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_seed();
    test_rollover();
    test_random(120, 0, 0);
    write_seed(32'hFFFF_FFFF);
    test_random(120, 47, 0);
    write_seed($urandom);
    test_random(120, 0, 47);
    write_seed(RESET_SEED);
    test_random(120, 33, 33);
    test_backpressure();
    wait_idle();
    // anything still owed here never arrived
    errors += read_bytes_due.size();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
